// File: rtl/hsv_knn_color_classifier_assert.svh
// Assertion macros for the HSV color classifier checkers.
// Both macros expect clk and rst_n in scope.
`ifndef HSV_KNN_COLOR_CLASSIFIER_ASSERT_SVH
`define HSV_KNN_COLOR_CLASSIFIER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define HSV_KNN_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv_knn check failed");

// Antecedent implies consequent in the next cycle.
`define HSV_KNN_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv_knn check failed");

`endif

// File: rtl/hsv_knn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_knn_pkg
// Shared types and constants of the HSV nearest-neighbor color classifier.
// ----------------------------------------------------------------------------
package hsv_knn_pkg;

    localparam int HUE_W   = 8;
    localparam int LABEL_W = 4;
    localparam int VOTES_W = 4;
    localparam int CAT_W   = 2;
    localparam int ADDR_W  = 3;

    localparam logic [HUE_W-1:0] HUE_TOP     = 8'd180;
    localparam logic [7:0]       BLACK_V_MAX = 8'd46;
    localparam logic [7:0]       GRAY_V_MAX  = 8'd220;
    localparam logic [7:0]       GRAY_S_MAX  = 8'd43;
    localparam logic [7:0]       WHITE_V_MIN = 8'd221;
    localparam logic [7:0]       WHITE_S_MAX = 8'd30;

    localparam logic [3:0] NC_RESET = 4'd5;
    localparam logic [8:0] EU_RESET = 9'd165;

    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    localparam logic REG_NEIGHBOUR_COUNT = 1'b0;
    localparam logic REG_ENTRIES_IN_USE  = 1'b1;

    typedef enum logic [CAT_W-1:0] {
        CAT_BLACK = 2'd0,
        CAT_GRAY  = 2'd1,
        CAT_WHITE = 2'd2,
        CAT_KNN   = 2'd3
    } category_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VOTE,
        ST_DONE
    } state_t;

endpackage

// File: rtl/hsv_knn_color_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_knn_color_classifier
// Load word: one per cycle while idle, writes one entry of the training memory.
// Band classify: result registered from ST_DONE once the output is free, then next word.
// Nearest-neighbor classify: scans n entries, one memory read per cycle, then votes
// over the list slots before ST_DONE; next word taken back in ST_IDLE; n = entries in use.
// Reset clears control, valid bits and registers (5, 165); memory is not reset.
// ----------------------------------------------------------------------------
module hsv_knn_color_classifier
    import hsv_knn_pkg::*;
#(
    parameter int MAX_ENTRIES    = 256,
    parameter int MAX_NEIGHBOURS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_ready,
    input  logic                kind,
    input  logic [7:0]          entry_index,
    input  logic [LABEL_W-1:0]  entry_label,
    input  logic [HUE_W-1:0]    entry_hue,
    input  logic [HUE_W-1:0]    query_hue,
    input  logic [7:0]          query_sat,
    input  logic [7:0]          query_value,

    output logic                result_valid,
    input  logic                result_ready,
    output logic [CAT_W-1:0]    category,
    output logic [LABEL_W-1:0]  label,
    output logic [VOTES_W-1:0]  votes,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NB = MAX_NEIGHBOURS;
    localparam int KW = $clog2(NB + 1);
    localparam int VW = (NB > 1) ? $clog2(NB) : 1;
    localparam int MW = LABEL_W + HUE_W;

    // training memory: {label, hue}
    logic [MW-1:0] mem [MAX_ENTRIES];
    logic [MW-1:0] rd_data_reg;

    state_t state_reg, state_next;

    logic [3:0]  nc_reg;
    logic [8:0]  eu_reg;

    logic [KW-1:0]      k_reg;
    logic [IW-1:0]      last_reg;
    logic [IW-1:0]      rd_addr_reg;
    logic               issue_reg;
    logic               pend_reg;
    logic [HUE_W-1:0]   qh_reg;
    logic [CAT_W-1:0]   pcat_reg;

    logic [NB-1:0]      nv_reg;
    logic [HUE_W-1:0]   dist_reg [NB];
    logic [LABEL_W-1:0] lab_reg  [NB];

    logic [VW-1:0]      vi_reg;
    logic [KW-1:0]      best_votes_reg;
    logic [LABEL_W-1:0] best_label_reg;

    logic               result_valid_reg;
    logic [CAT_W-1:0]   category_reg;
    logic [LABEL_W-1:0] label_reg;
    logic [VOTES_W-1:0] votes_reg;

    logic cfg_we;
    logic accept;
    logic load_we;
    logic start_classify;
    logic out_free;
    logic scan_end;
    logic vote_end;

    logic [31:0]        n_calc;
    logic [31:0]        k_calc;
    logic [HUE_W-1:0]   qh_sat;
    logic [HUE_W-1:0]   ehue_sat;
    logic [CAT_W-1:0]   band_cat;
    logic               band_hit;

    logic [HUE_W-1:0]   th;
    logic [HUE_W-1:0]   d;
    logic [NB-1:0]      le;
    logic [NB-1:0]      take_new;
    logic [NB-1:0]      shift_in;

    logic [LABEL_W-1:0] cur_lab;
    logic [KW-1:0]      cnt;
    logic               seen;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb
    begin
        if (paddr[2] == REG_NEIGHBOUR_COUNT)
        begin
            prdata = {28'd0, nc_reg};
        end
        else
        begin
            prdata = {23'd0, eu_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= NC_RESET;
            eu_reg <= EU_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_NEIGHBOUR_COUNT)
            begin
                nc_reg <= pwdata[3:0];
            end
            else
            begin
                eu_reg <= pwdata[8:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    assign accept         = item_valid & item_ready;
    assign load_we        = accept && (kind == KIND_LOAD) && (32'(entry_index) < MAX_ENTRIES);
    assign start_classify = accept && (kind == KIND_CLASSIFY);
    assign out_free       = !result_valid_reg || result_ready;
    assign scan_end       = !issue_reg && !pend_reg;
    assign vote_end       = (vi_reg == VW'(NB - 1));

    assign qh_sat   = (query_hue > HUE_TOP) ? HUE_TOP : query_hue;
    assign ehue_sat = (entry_hue > HUE_TOP) ? HUE_TOP : entry_hue;

    always_comb
    begin
        band_hit = 1'b1;
        band_cat = CAT_KNN;
        if (query_value <= BLACK_V_MAX)
        begin
            band_cat = CAT_BLACK;
        end
        else if (query_value <= GRAY_V_MAX && query_sat <= GRAY_S_MAX)
        begin
            band_cat = CAT_GRAY;
        end
        else if (query_value >= WHITE_V_MIN && query_sat <= WHITE_S_MAX)
        begin
            band_cat = CAT_WHITE;
        end
        else
        begin
            band_hit = 1'b0;
        end
    end

    always_comb
    begin
        n_calc = 32'(eu_reg);
        if (n_calc == 0)
        begin
            n_calc = 1;
        end
        else if (n_calc > MAX_ENTRIES)
        begin
            n_calc = MAX_ENTRIES;
        end
        k_calc = 32'(nc_reg);
        if (k_calc == 0)
        begin
            k_calc = 1;
        end
        else if (k_calc > NB)
        begin
            k_calc = NB;
        end
        if (k_calc > n_calc)
        begin
            k_calc = n_calc;
        end
    end

    // ------------------------------------------------------------------
    // training memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[IW'(entry_index)] <= {entry_label, ehue_sat};
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_classify)
                begin
                    state_next = band_hit ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_VOTE;
                end
            end
            ST_VOTE:
            begin
                if (vote_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:  item_ready = 1'b1;
            default:  item_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // scan: read one entry per cycle, insert into sorted nearest list
    // ------------------------------------------------------------------
    assign th = rd_data_reg[HUE_W-1:0];
    assign d  = (th > qh_reg) ? (th - qh_reg) : (qh_reg - th);

    always_comb
    begin
        for (int j = 0; j < NB; j++)
        begin
            le[j] = nv_reg[j] && (dist_reg[j] <= d);
        end
        for (int j = 0; j < NB; j++)
        begin
            if (j == 0)
            begin
                take_new[j] = (32'(k_reg) > j) && !le[j];
                shift_in[j] = 1'b0;
            end
            else
            begin
                take_new[j] = (32'(k_reg) > j) && le[j-1] && !le[j];
                shift_in[j] = (32'(k_reg) > j) && !le[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            rd_addr_reg <= '0;
            nv_reg      <= '0;
        end
        else
        begin
            pend_reg <= issue_reg;
            if (start_classify)
            begin
                issue_reg   <= !band_hit;
                rd_addr_reg <= '0;
                nv_reg      <= '0;
            end
            else if (issue_reg)
            begin
                if (rd_addr_reg == last_reg)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
            end
            if (pend_reg)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    if (take_new[j])
                    begin
                        nv_reg[j] <= 1'b1;
                    end
                    else if (shift_in[j])
                    begin
                        nv_reg[j] <= nv_reg[j-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_classify)
        begin
            qh_reg   <= qh_sat;
            k_reg    <= KW'(k_calc);
            last_reg <= IW'(n_calc - 1);
            pcat_reg <= band_cat;
        end
        if (pend_reg)
        begin
            for (int j = 0; j < NB; j++)
            begin
                if (take_new[j])
                begin
                    dist_reg[j] <= d;
                    lab_reg[j]  <= rd_data_reg[MW-1:HUE_W];
                end
                else if (shift_in[j])
                begin
                    dist_reg[j] <= dist_reg[j-1];
                    lab_reg[j]  <= lab_reg[j-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // vote: one list slot per cycle, first occurrence of a label counts
    // ------------------------------------------------------------------
    assign cur_lab = lab_reg[vi_reg];

    always_comb
    begin
        cnt  = '0;
        seen = 1'b0;
        for (int j = 0; j < NB; j++)
        begin
            if (nv_reg[j] && (lab_reg[j] == cur_lab))
            begin
                cnt = cnt + 1'b1;
                if (j < 32'(vi_reg))
                begin
                    seen = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vi_reg <= '0;
        end
        else if (start_classify)
        begin
            vi_reg <= '0;
        end
        else if (state_reg == ST_VOTE && !vote_end)
        begin
            vi_reg <= vi_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_classify)
        begin
            best_votes_reg <= '0;
            best_label_reg <= '0;
        end
        else if (state_reg == ST_VOTE && nv_reg[vi_reg] && !seen && cnt > best_votes_reg)
        begin
            best_votes_reg <= cnt;
            best_label_reg <= cur_lab;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            category_reg <= pcat_reg;
            label_reg    <= best_label_reg;
            votes_reg    <= VOTES_W'(best_votes_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign category     = category_reg;
    assign label        = label_reg;
    assign votes        = votes_reg;

endmodule

// File: rtl/hsv_knn_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_knn_chk
// Port-level checks of the HSV color classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsv_knn_color_classifier_assert.svh"

module hsv_knn_chk
    import hsv_knn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  logic                kind,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic [CAT_W-1:0]    category,
    input  logic [LABEL_W-1:0]  label,
    input  logic [VOTES_W-1:0]  votes
);

    `HSV_KNN_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(category) && $stable(label) && $stable(votes))
    `HSV_KNN_ASSERT_NOW(a_band_zero, result_valid && (category != CAT_KNN), (label == '0) && (votes == '0))
    `HSV_KNN_ASSERT_NEXT(a_load_silent, item_valid && item_ready && (kind == KIND_LOAD), !$rose(result_valid))
    `HSV_KNN_ASSERT_NEXT(a_classify_busy, item_valid && item_ready && (kind == KIND_CLASSIFY), !item_ready)

endmodule

bind hsv_knn_color_classifier hsv_knn_chk u_hsv_knn_chk (.*);
